// ===== src/mask_splat_accumulator_core_macros.svh =====
// ---------------------------------------------------------------------------
// Mask splat accumulator assertion macros
// Shared concurrent assertion forms used by the accumulator core.
// ---------------------------------------------------------------------------
`ifndef MASK_SPLAT_ACCUMULATOR_CORE_MACROS_SVH
`define MASK_SPLAT_ACCUMULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define MSAC_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MSAC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define MSAC_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define MSAC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== src/msac_pkg.sv =====
// ---------------------------------------------------------------------------
// Mask splat accumulator package
// Request and response types, request kinds, status codes and defaults.
// ---------------------------------------------------------------------------
package msac_pkg;

  // Default image size and default largest mask half size.
  localparam int IMG_DIM_DEF  = 256;
  localparam int MAX_HALF_DEF = 15;

  // Width of signed pixel coordinates used during a splat.
  localparam int COORD_W = 16;

  // Request kinds.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SPLAT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Response status codes.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_SAT   = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         mask_row;
    logic [4:0]         mask_col;
    logic [23:0]        mask_value;
    logic signed [15:0] pos_row;
    logic signed [15:0] pos_col;
    logic [15:0]        weight;
    logic [7:0]         pixel_row;
    logic [7:0]         pixel_col;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [1:0]  status;
  } rsp_t;

  // Status of the accumulate pipeline, seen by the sequencer.
  typedef struct packed {
    logic pipe_busy;
    logic sat_hit;
  } acc_stat_t;

endpackage

// ===== src/msac_accum_unit.sv =====
// ---------------------------------------------------------------------------
// Mask splat accumulator image unit
// Image memory with a read-multiply-add-saturate-write pipeline and a
// write path for the clearing pass.
// ---------------------------------------------------------------------------
module msac_accum_unit
  import msac_pkg::*;
#(
  parameter int IMG_DIM = IMG_DIM_DEF,
  localparam int AW = $clog2(IMG_DIM * IMG_DIM)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr_en,
  input  logic [AW-1:0]   clr_addr,
  input  logic            issue,
  input  logic [AW-1:0]   rd_addr,
  input  logic [15:0]     weight,
  input  logic [23:0]     mask_coef,
  output logic [31:0]     rd_data,
  output acc_stat_t       stat
);

  logic [31:0]   mem [IMG_DIM * IMG_DIM];
  logic          s1_v;
  logic          s2_v;
  logic [AW-1:0] s1_addr;
  logic [AW-1:0] s2_addr;
  logic [39:0]   s2_prod;
  logic [31:0]   s2_img;
  logic [32:0]   add_q16;
  logic [33:0]   sum;
  logic          sat;
  logic [31:0]   acc_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // Registered read port, shared by splat accesses and pixel reads.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
  end

  // Stage one multiplies the coefficient by the weight (Q16.24 product).
  always_ff @(posedge clk) begin
    s1_addr <= rd_addr;
    s2_addr <= s1_addr;
    s2_prod <= {16'd0, mask_coef} * {24'd0, weight};
    s2_img  <= rd_data;
  end

  // Stage two rounds to Q16.16, adds to the pixel and saturates.
  always_comb begin
    add_q16  = 33'((41'(s2_prod) + 41'd128) >> 8);
    sum      = 34'(s2_img) + 34'(add_q16);
    sat      = (sum[33:32] != 2'b00);
    acc_data = sat ? 32'hFFFF_FFFF : sum[31:0];
  end

  // The clearing pass and splat writes never overlap.
  assign wr_en   = clr_en | s2_v;
  assign wr_addr = clr_en ? clr_addr : s2_addr;
  assign wr_data = clr_en ? 32'd0 : acc_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign stat.pipe_busy = s1_v | s2_v;
  assign stat.sat_hit   = s2_v & sat;

endmodule

// ===== src/mask_splat_accumulator_core.sv =====
// ---------------------------------------------------------------------------
// Mask splat accumulator core
// Splats a loaded square mask, scaled by a weight, into an image accumulator.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. It is
//   a mask coefficient load, a splat at a Q12.4 position, or a pixel read.
//   Each request gives one response on rsp, marked by done for one cycle.
//   The receiver cannot stall, so the response must be captured that cycle.
//   A load or a rejected request answers in the next cycle, a pixel read
//   after the read state. A splat walks the (2h+1)^2 mask cells in turn,
//   h being the clamped mask_half_size, issuing an image read-modify-write
//   through the image memory port for each cell inside the image without
//   waiting for the previous one, then drains the accumulate pipeline,
//   answering sooner when its last cells fall outside the image. busy stays
//   high until a splat or pixel read answers, so one request is at work at
//   a time. After reset the image memory is cleared one pixel per cycle
//   with busy high. The mask store is not cleared; every cell a splat uses
//   must be loaded. The user must write mask_half_size through
//   cfg_we/cfg_data only while idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`include "mask_splat_accumulator_core_macros.svh"

module mask_splat_accumulator_core
  import msac_pkg::*;
#(
  parameter int IMG_DIM  = IMG_DIM_DEF,
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       start,
  input  req_t       req,
  output logic       busy,
  output logic       done,
  output rsp_t       rsp
);

  localparam int MASK_DIM = 2 * MAX_HALF + 1;
  localparam int AW       = $clog2(IMG_DIM * IMG_DIM);
  localparam int RW       = $clog2(IMG_DIM);
  localparam int MAW      = $clog2(MASK_DIM * MASK_DIM);
  localparam int HW       = $clog2(MASK_DIM);
  localparam int HCW      = (HW > 4) ? HW : 4;

  localparam logic [AW-1:0]              CLR_LAST = AW'(IMG_DIM * IMG_DIM - 1);
  localparam logic [HW-1:0]              MH_U     = HW'(MAX_HALF);
  localparam logic signed [COORD_W-1:0]  MH_S     = COORD_W'(MAX_HALF);
  localparam logic signed [COORD_W-1:0]  DIM_S    = COORD_W'(IMG_DIM);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SPLAT = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  // Round a signed Q12.4 value to the nearest pixel, halves away from zero.
  function automatic logic signed [COORD_W-1:0] round_pos(input logic [15:0] u);
    logic [16:0] mag;
    logic [12:0] rnd;
    mag = u[15] ? (17'h10000 - {1'b0, u}) : {1'b0, u};
    rnd = 13'((mag + 17'd8) >> 4);
    round_pos = u[15] ? -$signed(COORD_W'(rnd)) : $signed(COORD_W'(rnd));
  endfunction

  logic [2:0]                state;
  logic [3:0]                half_size;
  logic [AW-1:0]             clr_cnt;
  logic                      sat_flag;
  logic signed [COORD_W-1:0] ctr_r;
  logic signed [COORD_W-1:0] ctr_c;
  logic [15:0]               wgt;
  logic [HW-1:0]             row_idx;
  logic [HW-1:0]             col_idx;
  logic [23:0]               mask_mem [MASK_DIM * MASK_DIM];
  logic [23:0]               mask_q;

  logic [HCW-1:0]            hs_ext;
  logic [HCW-1:0]            mh_ext;
  logic [HW-1:0]             h_eff;
  logic [HW-1:0]             idx_lo;
  logic [HW-1:0]             idx_hi;
  logic                      last_col;
  logic                      last_row;
  logic signed [COORD_W-1:0] r_pos;
  logic signed [COORD_W-1:0] c_pos;
  logic                      r_in;
  logic                      c_in;
  logic [AW-1:0]             splat_addr;
  logic [AW-1:0]             pix_addr;
  logic [AW-1:0]             img_raddr;
  logic [MAW-1:0]            mask_raddr;
  logic [MAW-1:0]            mask_waddr;
  logic                      load_ok;
  logic                      pix_ok;
  logic                      accept;
  logic                      mask_we;
  logic                      issue;
  logic [1:0]                req_status;
  logic [31:0]               img_q;
  acc_stat_t                 acc_stat;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  // Effective half size, clamped to the largest mask.
  always_comb begin
    hs_ext = HCW'(half_size);
    mh_ext = HCW'(MAX_HALF);
    h_eff  = HW'((hs_ext > mh_ext) ? mh_ext : hs_ext);
    idx_lo = MH_U - h_eff;
    idx_hi = MH_U + h_eff;
  end

  // Current splat cell: image coordinates, bounds and addresses.
  always_comb begin
    last_col   = (col_idx == idx_hi);
    last_row   = (row_idx == idx_hi);
    r_pos      = ctr_r + $signed(COORD_W'(row_idx)) - MH_S;
    c_pos      = ctr_c + $signed(COORD_W'(col_idx)) - MH_S;
    r_in       = !r_pos[COORD_W-1] && (r_pos < DIM_S);
    c_in       = !c_pos[COORD_W-1] && (c_pos < DIM_S);
    splat_addr = AW'(AW'(r_pos[RW-1:0]) * AW'(IMG_DIM) + AW'(c_pos[RW-1:0]));
    mask_raddr = MAW'(MAW'(row_idx) * MAW'(MASK_DIM) + MAW'(col_idx));
  end

  // Request decode.
  always_comb begin
    load_ok    = (32'(req.mask_row) < 32'(MASK_DIM)) && (32'(req.mask_col) < 32'(MASK_DIM));
    pix_ok     = (32'(req.pixel_row) < 32'(IMG_DIM)) && (32'(req.pixel_col) < 32'(IMG_DIM));
    mask_waddr = MAW'(MAW'(req.mask_row) * MAW'(MASK_DIM) + MAW'(req.mask_col));
    pix_addr   = AW'(AW'(req.pixel_row) * AW'(IMG_DIM) + AW'(req.pixel_col));
    case (req.req_type)
      REQ_LOAD:  req_status = load_ok ? STS_OK : STS_RANGE;
      REQ_SPLAT: req_status = STS_OK;
      REQ_READ:  req_status = pix_ok ? STS_OK : STS_RANGE;
      default:   req_status = STS_RANGE;
    endcase
  end

  assign mask_we   = accept && (req.req_type == REQ_LOAD) && load_ok;
  assign issue     = (state == S_SPLAT) && r_in && c_in;
  assign img_raddr = (state == S_SPLAT) ? splat_addr : pix_addr;

  // Mask store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= req.mask_value;
    end
    mask_q <= mask_mem[mask_raddr];
  end

  // Image memory and accumulate pipeline.
  msac_accum_unit #(
    .IMG_DIM (IMG_DIM)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .clr_en    (state == S_CLEAR),
    .clr_addr  (clr_cnt),
    .issue     (issue),
    .rd_addr   (img_raddr),
    .weight    (wgt),
    .mask_coef (mask_q),
    .rd_data   (img_q),
    .stat      (acc_stat)
  );

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      half_size <= 4'd0;
      clr_cnt   <= '0;
      sat_flag  <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        half_size <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (req.req_type)
              REQ_SPLAT: begin
                state    <= S_SPLAT;
                sat_flag <= 1'b0;
              end
              REQ_READ: begin
                if (pix_ok) begin
                  state <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SPLAT: begin
          if (last_col && last_row) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!acc_stat.pipe_busy) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_READ: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
      if (acc_stat.sat_hit) begin
        sat_flag <= 1'b1;
      end
    end
  end

  // Splat operands, mask cell counters and the response register.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          ctr_r      <= round_pos(req.pos_row);
          ctr_c      <= round_pos(req.pos_col);
          wgt        <= req.weight;
          row_idx    <= idx_lo;
          col_idx    <= idx_lo;
          rsp.pixel_value <= 32'd0;
          rsp.status      <= req_status;
        end
      end
      S_SPLAT: begin
        if (last_col) begin
          col_idx <= idx_lo;
          row_idx <= row_idx + HW'(1);
        end else begin
          col_idx <= col_idx + HW'(1);
        end
      end
      S_DRAIN: begin
        if (!acc_stat.pipe_busy) begin
          rsp.pixel_value <= 32'd0;
          rsp.status      <= sat_flag ? STS_SAT : STS_OK;
        end
      end
      S_READ: begin
        rsp.pixel_value <= img_q;
        rsp.status      <= STS_OK;
      end
      default: begin
      end
    endcase
  end

  // A response only appears once the block is idle again.
  `MSAC_ASSERT_IMPLY(a_done_when_idle, clk, rst, done, !busy)
  // Every accepted request either answers at once or keeps the block busy.
  `MSAC_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, done || busy)
  // The accumulate pipeline is empty whenever a new request can enter.
  `MSAC_ASSERT_IMPLY(a_idle_pipe_empty, clk, rst, !busy, !acc_stat.pipe_busy)

endmodule
